// ----- src/b2rng_pkg.sv -----
// Types, constants and tables shared across the BLAKE2s reseeding generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package b2rng_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned VEC_N   = 16;
	localparam int unsigned MSG_N   = 16;
	localparam int unsigned CHAIN_N = 8;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned STEPS   = 160;

	localparam logic [2:0] REG_ID01     = 3'd0;
	localparam logic [2:0] REG_ID23     = 3'd1;
	localparam logic [2:0] REG_ID45     = 3'd2;
	localparam logic [2:0] REG_ID67     = 3'd3;
	localparam logic [2:0] REG_INTERVAL = 3'd4;

	localparam logic [15:0] INTERVAL_RST = 16'd1000;
	localparam logic [31:0] DIGEST_BYTES = 32'd32;
	localparam logic [31:0] BLOCK_BYTES  = 32'd64;
	localparam logic [31:0] PARAM_WORD   = 32'h0101_0000;

	localparam logic [0:0] ACT_ENTROPY  = 1'b0;
	localparam logic [0:0] ACT_GENERATE = 1'b1;
	localparam logic [0:0] ST_OK        = 1'b0;
	localparam logic [0:0] ST_NOT_READY = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [VEC_N-1:0][WORD_W-1:0] vec_t;
	typedef logic [3:0][WORD_W-1:0] row_t;

	typedef struct packed {
		logic        action;
		logic [31:0] entropy_word;
	} req_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic        last;
		logic        status;
		logic [31:0] reseed_count;
	} rsp_t;

	localparam word_t IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [3:0] PERM [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	function automatic logic [3:0] msg_sel(input logic [7:0] step);
		logic [3:0] rnd;
		rnd = step[7:4];
		if (rnd < 4'd10) begin
			return PERM[rnd][step[3:0]];
		end
		return 4'd0;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		h = IV[i];
		if (i == 3'd0) begin
			h = h ^ PARAM_WORD ^ DIGEST_BYTES;
		end
		return h;
	endfunction

endpackage

// ----- src/b2rng_if.sv -----
// Valid/ready channels for request and result words.
// Depends on b2rng_pkg for the payload types.
`timescale 1ns / 1ps

interface b2rng_req_if;
	logic               valid;
	logic               ready;
	b2rng_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface b2rng_rsp_if;
	logic               valid;
	logic               ready;
	b2rng_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/b2rng_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module b2rng_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/b2rng_mix.sv -----
// One half of the BLAKE2s mixing function on fixed vector positions, plus row rotation.
// Depends on b2rng_pkg.
`timescale 1ns / 1ps

module b2rng_mix (
	input  b2rng_pkg::vec_t    v,
	input  b2rng_pkg::word_t   x,
	input  logic [3:0]         step,
	output b2rng_pkg::vec_t    v_next
);
	import b2rng_pkg::*;

	function automatic word_t rotr(input word_t w, input logic [4:0] n);
		return (w >> n) | (w << (6'd32 - {1'b0, n}));
	endfunction

	function automatic row_t rot_row(input row_t r, input logic [1:0] amt);
		row_t o;
		for (int k = 0; k < 4; k++) begin
			o[k] = r[2'(k) + amt];
		end
		return o;
	endfunction

	word_t a, b, c, d;
	logic [4:0] r1, r2;
	logic [2:0] g;
	vec_t mixed;
	row_t row_in [4];
	logic [1:0] amt [4];

	always_comb begin
		g = step[3:1];
		r1 = step[0] ? 5'd8 : 5'd16;
		r2 = step[0] ? 5'd7 : 5'd12;
		a = v[0] + v[4] + x;
		d = rotr(v[12] ^ a, r1);
		c = v[8] + d;
		b = rotr(v[4] ^ c, r2);
		mixed = v;
		mixed[0] = a;
		mixed[4] = b;
		mixed[8] = c;
		mixed[12] = d;
		for (int r = 0; r < 4; r++) begin
			row_in[r] = mixed[4*r +: 4];
			if (!step[0]) begin
				amt[r] = 2'd0;
			end else if (g == 3'd3) begin
				amt[r] = 2'd1 + 2'(r);
			end else if (g == 3'd7) begin
				amt[r] = 2'd1 - 2'(r);
			end else begin
				amt[r] = 2'd1;
			end
			v_next[4*r +: 4] = rot_row(row_in[r], amt[r]);
		end
	end
endmodule

// ----- src/blake2s_reseeding_rng.sv -----
// BLAKE2s reseeding random generator: top level, sequencer and state memory.
// Depends on b2rng_pkg, b2rng_if, b2rng_ram and b2rng_mix.
//
// req carries words of {action, entropy_word}. An entropy word (action 0)
// is stored and gives no result; eight are needed after reset and after
// every reseed, further ones are dropped. A generate word (action 1)
// hashes the 16-word state held in a 16x32 RAM with one shared half-mixing
// unit: ten rounds (one message word read from the RAM per cycle), a
// write-back of the eight digest words, a step that adds the generation
// count to word 15, then OUTPUT_WORDS result words, one per cycle while
// rsp is free. A generate while entropy is pending gives one not-ready
// word. req is taken only when the sequencer is idle; the last result
// may still sit in the output register while the next word is accepted.
// When rsp stalls the output register holds and the sequencer waits.
// Reset (arst_n low) clears identity words, counters and flags and sets the
// reseed interval to 1000; no clearing pass runs. cfg_we writes register
// cfg_idx (0..3 identity pairs, ignored once seeded; 4 reseed interval).
`timescale 1ns / 1ps

module blake2s_reseeding_rng #(
	parameter int unsigned OUTPUT_WORDS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [b2rng_pkg::CFG_W-1:0] cfg_data,
	b2rng_req_if.sink                   req,
	b2rng_rsp_if.source                 rsp
);
	import b2rng_pkg::*;

	typedef enum logic [2:0] {
		IDLE, RUN, WB, ADDW, EMIT, NRDY
	} state_t;

	state_t      state_q;
	logic [7:0]  step_q;
	logic [2:0]  idx_q;
	logic [3:0]  fill_q;
	logic        seeded_q;
	logic        chain_valid_q;
	logic [15:0] gen_q;
	logic [15:0] interval_q;
	logic [31:0] reseed_q;
	logic [31:0] cnt_q;
	word_t       pre_q [CHAIN_N];
	vec_t        v_q;
	logic [3:0]  addr_s1;
	logic        out_valid_q;
	rsp_t        out_q;

	logic        ram_we;
	logic [3:0]  ram_waddr;
	word_t       ram_wdata;
	logic [3:0]  ram_raddr;
	word_t       ram_rdata;
	word_t       msg_x;
	vec_t        v_mix;
	word_t       dig [CHAIN_N];
	logic [7:0]  step_nx;
	logic [15:0] gen_nx;
	logic        accept;
	logic        slot_free;
	logic        load_out;
	logic [2:0]  last_idx;

	assign last_idx  = 3'(OUTPUT_WORDS - 1);
	assign req.ready = (state_q == IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign load_out  = slot_free && (state_q == EMIT || state_q == NRDY);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign step_nx   = step_q + 8'd1;
	assign gen_nx    = gen_q + 16'd1;
	assign msg_x     = (!addr_s1[3] && !chain_valid_q) ? pre_q[addr_s1[2:0]] : ram_rdata;

	always_comb begin
		for (int i = 0; i < CHAIN_N; i++) begin
			dig[i] = init_h(3'(i)) ^ v_q[i] ^ v_q[i+8];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {1'b1, fill_q[2:0]};
		ram_wdata = req.data.entropy_word;
		case (state_q)
			IDLE: begin
				ram_raddr = msg_sel(8'd0);
				ram_we = accept && req.data.action == ACT_ENTROPY && !fill_q[3];
			end
			RUN: ram_raddr = msg_sel(step_nx);
			WB: begin
				ram_raddr = 4'd15;
				ram_we    = 1'b1;
				ram_waddr = {1'b0, idx_q};
				ram_wdata = dig[idx_q];
			end
			ADDW: begin
				ram_raddr = 4'd15;
				ram_we    = 1'b1;
				ram_waddr = 4'd15;
				ram_wdata = ram_rdata + {16'd0, gen_nx};
			end
			default: ram_raddr = 4'd0;
		endcase
	end

	b2rng_ram #(.WIDTH(WORD_W), .DEPTH(MSG_N)) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	b2rng_mix u_mix (
		.v      (v_q),
		.x      (msg_x),
		.step   (step_q[3:0]),
		.v_next (v_mix)
	);

	always_ff @(posedge clk) begin
		addr_s1 <= ram_raddr;
		if (accept) begin
			cnt_q <= reseed_q;
			for (int i = 0; i < CHAIN_N; i++) begin
				v_q[i]   <= init_h(3'(i));
				v_q[i+8] <= (i == 4) ? (IV[4] ^ BLOCK_BYTES) :
				            (i == 6) ? ~IV[6] : IV[i];
			end
		end else if (state_q == RUN) begin
			v_q <= v_mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			step_q        <= '0;
			idx_q         <= '0;
			fill_q        <= '0;
			seeded_q      <= 1'b0;
			chain_valid_q <= 1'b0;
			gen_q         <= '0;
			interval_q    <= INTERVAL_RST;
			reseed_q      <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
			for (int i = 0; i < CHAIN_N; i++) begin
				pre_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ID01, REG_ID23, REG_ID45, REG_ID67: begin
						if (!seeded_q) begin
							pre_q[{cfg_idx[1:0], 1'b0}] <= cfg_data[31:0];
							pre_q[{cfg_idx[1:0], 1'b1}] <= cfg_data[63:32];
						end
					end
					REG_INTERVAL: interval_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (req.data.action == ACT_ENTROPY) begin
							if (!fill_q[3]) begin
								fill_q <= fill_q + 4'd1;
								if (fill_q == 4'd7) begin
									seeded_q <= 1'b1;
								end
							end
						end else if (fill_q[3]) begin
							step_q  <= '0;
							state_q <= RUN;
						end else begin
							state_q <= NRDY;
						end
					end
				end
				RUN: begin
					step_q <= step_nx;
					if (step_q == 8'(STEPS - 1)) begin
						idx_q   <= '0;
						state_q <= WB;
					end
				end
				WB: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_q <= ADDW;
					end
				end
				ADDW: begin
					chain_valid_q <= 1'b1;
					if (gen_nx == interval_q) begin
						gen_q    <= '0;
						reseed_q <= reseed_q + 32'd1;
						fill_q   <= '0;
					end else begin
						gen_q <= gen_nx;
					end
					idx_q   <= '0;
					state_q <= EMIT;
				end
				EMIT: begin
					if (slot_free) begin
						out_q.random_word  <= dig[idx_q];
						out_q.last         <= (idx_q == last_idx);
						out_q.status       <= ST_OK;
						out_q.reseed_count <= cnt_q;
						idx_q              <= idx_q + 3'd1;
						if (idx_q == last_idx) begin
							state_q <= IDLE;
						end
					end
				end
				NRDY: begin
					if (slot_free) begin
						out_q.random_word  <= '0;
						out_q.last         <= 1'b1;
						out_q.status       <= ST_NOT_READY;
						out_q.reseed_count <= cnt_q;
						state_q            <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_chain_after_seed: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid_q |-> seeded_q) else $error("chain written before seeding");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'd8) else $error("entropy fill index overflow");
	a_hash_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> fill_q[3]) else $error("hash started without entropy");
	a_notready_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_NOT_READY) |-> out_q.last)
		else $error("not-ready word not marked last");
`endif
endmodule
